### rtl/infix_expression_evaluator_assert.svh
// Assertion macros for the infix expression evaluator.
// Used by the top level; expects clk_i and rst_ni in the scope of each use.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`ifndef SYNTH
`define IEE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("infix evaluator check failed");
`define IEE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("infix evaluator check failed");
`else
`define IEE_ASSERT_IMP(lbl, ante, cons)
`define IEE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/iee_pkg.sv
// Shared constants, codes and helper functions of the infix expression evaluator.
// No dependencies; used by the evaluator top level and the multiply/divide unit.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;

  localparam int unsigned VALUE_W         = 48;
  localparam int unsigned LIT_W           = 31;
  localparam int unsigned SYM_W           = 5;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned ST_W            = 3;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam logic [VALUE_W-1:0] VMAX_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VMIN_NEG = 48'h8000_0000_0000;
  localparam logic [LIT_W-1:0]   LIT_MAX  = 31'h7FFF_FFFF;

  // Input symbol codes.
  localparam logic [SYM_W-1:0] SYM_DIGIT_MAX = 5'd9;
  localparam logic [SYM_W-1:0] SYM_LPAREN    = 5'd10;
  localparam logic [SYM_W-1:0] SYM_RPAREN    = 5'd11;
  localparam logic [SYM_W-1:0] SYM_ADD       = 5'd12;
  localparam logic [SYM_W-1:0] SYM_SUB       = 5'd13;
  localparam logic [SYM_W-1:0] SYM_MUL       = 5'd14;
  localparam logic [SYM_W-1:0] SYM_DIV       = 5'd15;
  localparam logic [SYM_W-1:0] SYM_END       = 5'd16;

  // Operator stack codes.
  localparam logic [OP_W-1:0] OP_LPAREN = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_MALFORMED = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV_ZERO  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [ST_W-1:0] ST_SATURATED = 3'd4;

  function automatic logic is_fatal(input logic [ST_W-1:0] err);
    return (err == ST_MALFORMED) || (err == ST_DIV_ZERO) || (err == ST_OVERFLOW);
  endfunction

  // The first hard error wins and replaces a saturation flag.
  function automatic logic [ST_W-1:0] raise_err(input logic [ST_W-1:0] err,
                                                input logic [ST_W-1:0] code);
    return is_fatal(err) ? err : code;
  endfunction

  function automatic logic [ST_W-1:0] note_sat(input logic [ST_W-1:0] err);
    return (err == ST_OK) ? ST_SATURATED : err;
  endfunction

  function automatic logic op_prio_high(input logic [OP_W-1:0] op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage
`default_nettype wire

### rtl/infix_expression_evaluator.sv
// Infix expression evaluator top level: control sequencer and stack memories.
// Depends on iee_pkg, iee_stack_ram, iee_muldiv and the assertion macro header.
//
// Usage: symbols arrive on the input channel (in_valid_i, in_stall_o, symbol_i),
// one request per symbol: digits 0-9, '(' 10, ')' 11, + 12, - 13, * 14, / 15 and
// the end marker 16. Only the end marker gives a result on the output channel
// (out_valid_o, out_stall_i, value_o, status_o): a 48-bit fixed-point value and
// a status code. A digit or '(' is decoded and taken; an operator, ')' or the end
// marker also pushes a pending literal and reduces while the top of the operator
// stack demands it, * in the multiply unit (one 48x16 partial product per cycle),
// / in the divide unit (one quotient bit per cycle) and + or - in place. All stack
// reads go through the synchronous memories with registered read data.
// After reset both stacks are empty and no result is pending; the stack memory
// contents are never read before they are written. A result waits in the
// output register while the receiver stalls; further symbols are still taken
// until the next end marker needs the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_expression_evaluator_assert.svh"
module infix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [iee_pkg::SYM_W-1:0]     symbol_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [iee_pkg::VALUE_W-1:0] value_o,
  output logic [iee_pkg::ST_W-1:0]           status_o
);

  localparam int unsigned VW    = iee_pkg::VALUE_W;
  localparam int unsigned LW    = iee_pkg::LIT_W;
  localparam int unsigned SW    = iee_pkg::SYM_W;
  localparam int unsigned OW    = iee_pkg::OP_W;
  localparam int unsigned EW    = iee_pkg::ST_W;
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CLOSE  = 4'd2;
  localparam logic [3:0] S_TOPRD  = 4'd3;
  localparam logic [3:0] S_TOPCHK = 4'd4;
  localparam logic [3:0] S_OPER   = 4'd5;
  localparam logic [3:0] S_WAIT   = 4'd6;
  localparam logic [3:0] S_OUTRD  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [SW-1:0]  sym_q, sym_d;
  logic [CNT_W-1:0] num_cnt_q, num_cnt_d;
  logic [CNT_W-1:0] op_cnt_q, op_cnt_d;
  logic [LW-1:0]  acc_q, acc_d;
  logic           in_lit_q, in_lit_d;
  logic           after_op_q, after_op_d;
  logic [EW-1:0]  err_q, err_d;
  logic [OW-1:0]  top_op_q, top_op_d;
  logic           out_valid_q, out_valid_d;
  logic [VW-1:0]  value_q, value_d;
  logic [EW-1:0]  status_q, status_d;

  // Memory ports.
  logic           n_we;
  logic [AW-1:0]  n_waddr;
  logic [VW-1:0]  n_wdata;
  logic           n_re;
  logic [AW-1:0]  n_raddr_a, n_raddr_b;
  logic [VW-1:0]  n_rdata_a, n_rdata_b;
  logic           o_we;
  logic [AW-1:0]  o_waddr;
  logic [OW-1:0]  o_wdata;
  logic           o_re;
  logic [AW-1:0]  o_raddr;
  logic [OW-1:0]  o_rdata;

  // Arithmetic unit.
  logic           alu_start, alu_div, alu_busy, alu_done, alu_sat;
  logic [VW-1:0]  alu_result;

  logic [SW-1:0]  fin_state_sym;
  logic [3:0]     fin_state;
  logic [LW+3:0]  acc_next;
  logic [63:0]    lit_v;
  logic [OW-1:0]  new_op;
  logic           top_is_op, do_reduce;
  logic [VW:0]    sum;
  logic [VW-1:0]  sum_sat;
  logic           sum_ovf;
  logic           out_load;

  assign fin_state_sym = sym_q;
  assign fin_state     = (fin_state_sym == iee_pkg::SYM_END) ? S_OUT : S_IDLE;
  assign acc_next      = (LW+4)'(acc_q) * (LW+4)'(10) + (LW+4)'(sym_q);
  assign lit_v         = 64'(acc_q) << FRAC_BITS;
  assign new_op        = OW'(sym_q - iee_pkg::SYM_RPAREN);
  assign top_is_op     = (op_cnt_q != '0) && (o_rdata != iee_pkg::OP_LPAREN);
  assign do_reduce     = top_is_op &&
                         ((sym_q == iee_pkg::SYM_RPAREN) || (sym_q == iee_pkg::SYM_END) ||
                          (iee_pkg::op_prio_high(o_rdata) || !iee_pkg::op_prio_high(new_op)));
  assign sum           = (top_op_q == iee_pkg::OP_SUB) ?
                         ({n_rdata_b[VW-1], n_rdata_b} - {n_rdata_a[VW-1], n_rdata_a}) :
                         ({n_rdata_b[VW-1], n_rdata_b} + {n_rdata_a[VW-1], n_rdata_a});
  assign sum_ovf       = sum[VW] ^ sum[VW-1];
  assign sum_sat       = sum_ovf ? (sum[VW] ? iee_pkg::VMIN_NEG : iee_pkg::VMAX_POS)
                                 : sum[VW-1:0];
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    num_cnt_d   = num_cnt_q;
    op_cnt_d    = op_cnt_q;
    acc_d       = acc_q;
    in_lit_d    = in_lit_q;
    after_op_d  = after_op_q;
    err_d       = err_q;
    top_op_d    = top_op_q;
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    status_d    = status_q;
    n_we        = 1'b0;
    n_waddr     = AW'(num_cnt_q);
    n_wdata     = sum_sat;
    n_re        = 1'b0;
    n_raddr_a   = AW'(num_cnt_q - 1'b1);
    n_raddr_b   = AW'(num_cnt_q - 2'd2);
    o_we        = 1'b0;
    o_waddr     = AW'(op_cnt_q);
    o_wdata     = new_op;
    o_re        = 1'b0;
    o_raddr     = AW'(op_cnt_q - 1'b1);
    alu_start   = 1'b0;
    alu_div     = (top_op_q == iee_pkg::OP_DIV);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d   = symbol_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        if (sym_q == iee_pkg::SYM_END) begin
          if (iee_pkg::is_fatal(err_q)) begin
            state_d = S_OUT;
          end else if (!after_op_q) begin
            err_d   = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
            state_d = S_OUT;
          end else begin
            state_d = S_CLOSE;
          end
        end else if (iee_pkg::is_fatal(err_q)) begin
          state_d = S_IDLE;
        end else if (sym_q <= iee_pkg::SYM_DIGIT_MAX) begin
          if (after_op_q && !in_lit_q) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
          end else begin
            if (acc_next > (LW+4)'(iee_pkg::LIT_MAX)) begin
              err_d = iee_pkg::note_sat(err_q);
              acc_d = iee_pkg::LIT_MAX;
            end else begin
              acc_d = acc_next[LW-1:0];
            end
            in_lit_d   = 1'b1;
            after_op_d = 1'b1;
          end
        end else if (sym_q == iee_pkg::SYM_LPAREN) begin
          if (after_op_q) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
          end else if (op_cnt_q >= CNT_W'(STACK_DEPTH)) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_OVERFLOW);
          end else begin
            o_we     = 1'b1;
            o_wdata  = iee_pkg::OP_LPAREN;
            op_cnt_d = op_cnt_q + 1'b1;
          end
        end else if (sym_q <= iee_pkg::SYM_DIV) begin
          if (!after_op_q) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
          end else begin
            state_d = S_CLOSE;
          end
        end else begin
          err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
        end
      end
      S_CLOSE: begin
        if (in_lit_q) begin
          n_wdata = lit_v[VW-1:0];
          if (lit_v > 64'(iee_pkg::VMAX_POS)) begin
            err_d   = iee_pkg::note_sat(err_q);
            n_wdata = iee_pkg::VMAX_POS;
          end
          if (num_cnt_q >= CNT_W'(STACK_DEPTH)) begin
            err_d = iee_pkg::raise_err(err_d, iee_pkg::ST_OVERFLOW);
          end else begin
            n_we      = 1'b1;
            num_cnt_d = num_cnt_q + 1'b1;
          end
          in_lit_d = 1'b0;
          acc_d    = '0;
        end
        state_d = S_TOPRD;
      end
      S_TOPRD: begin
        if (iee_pkg::is_fatal(err_q)) begin
          state_d = fin_state;
        end else begin
          o_re    = (op_cnt_q != '0);
          state_d = S_TOPCHK;
        end
      end
      S_TOPCHK: begin
        if (do_reduce) begin
          top_op_d = o_rdata;
          op_cnt_d = op_cnt_q - 1'b1;
          if (num_cnt_q < CNT_W'(2)) begin
            err_d   = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
            state_d = fin_state;
          end else begin
            n_re    = 1'b1;
            state_d = S_OPER;
          end
        end else if (sym_q == iee_pkg::SYM_END) begin
          if ((op_cnt_q != '0) || (num_cnt_q != CNT_W'(1))) begin
            err_d   = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
            state_d = S_OUT;
          end else begin
            state_d = S_OUTRD;
          end
        end else if (sym_q == iee_pkg::SYM_RPAREN) begin
          if (op_cnt_q == '0) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
          end else begin
            op_cnt_d   = op_cnt_q - 1'b1;
            after_op_d = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          if (op_cnt_q >= CNT_W'(STACK_DEPTH)) begin
            err_d = iee_pkg::raise_err(err_q, iee_pkg::ST_OVERFLOW);
          end else begin
            o_we     = 1'b1;
            op_cnt_d = op_cnt_q + 1'b1;
          end
          after_op_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_OPER: begin
        num_cnt_d = num_cnt_q - 2'd2;
        case (top_op_q) inside
          iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
            // Result replaces the left operand in place.
            n_we      = 1'b1;
            n_waddr   = AW'(num_cnt_q - 2'd2);
            num_cnt_d = num_cnt_q - 1'b1;
            if (sum_ovf) begin
              err_d = iee_pkg::note_sat(err_q);
            end
            state_d = S_TOPRD;
          end
          iee_pkg::OP_MUL: begin
            alu_start = 1'b1;
            state_d   = S_WAIT;
          end
          iee_pkg::OP_DIV: begin
            if (n_rdata_a == '0) begin
              err_d   = iee_pkg::raise_err(err_q, iee_pkg::ST_DIV_ZERO);
              state_d = fin_state;
            end else begin
              alu_start = 1'b1;
              state_d   = S_WAIT;
            end
          end
          default: begin
            err_d   = iee_pkg::raise_err(err_q, iee_pkg::ST_MALFORMED);
            state_d = fin_state;
          end
        endcase
      end
      S_WAIT: begin
        if (alu_done) begin
          n_we      = 1'b1;
          n_wdata   = alu_result;
          num_cnt_d = num_cnt_q + 1'b1;
          if (alu_sat) begin
            err_d = iee_pkg::note_sat(err_q);
          end
          state_d = S_TOPRD;
        end
      end
      S_OUTRD: begin
        n_re      = 1'b1;
        n_raddr_a = '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          value_d     = iee_pkg::is_fatal(err_q) ? '0 : n_rdata_a;
          status_d    = err_q;
          num_cnt_d   = '0;
          op_cnt_d    = '0;
          acc_d       = '0;
          in_lit_d    = 1'b0;
          after_op_d  = 1'b0;
          err_d       = iee_pkg::ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_cnt_q   <= '0;
      op_cnt_q    <= '0;
      acc_q       <= '0;
      in_lit_q    <= 1'b0;
      after_op_q  <= 1'b0;
      err_q       <= iee_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_cnt_q   <= num_cnt_d;
      op_cnt_q    <= op_cnt_d;
      acc_q       <= acc_d;
      in_lit_q    <= in_lit_d;
      after_op_q  <= after_op_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    top_op_q <= top_op_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  // The number stack is kept twice so both operands are read in the same cycle.
  iee_stack_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_num_a (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr_a),
    .rdata_o (n_rdata_a)
  );

  iee_stack_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_num_b (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr_b),
    .rdata_o (n_rdata_b)
  );

  iee_stack_ram #(.WIDTH(OW), .DEPTH(STACK_DEPTH)) u_op (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .re_i    (o_re),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  iee_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (alu_start),
    .is_div_i (alu_div),
    .x_i      (n_rdata_b),
    .y_i      (n_rdata_a),
    .busy_o   (alu_busy),
    .done_o   (alu_done),
    .result_o (alu_result),
    .sat_o    (alu_sat)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);
  assign status_o    = status_q;

  `IEE_ASSERT_IMP(a_num_bound, 1'b1, num_cnt_q <= CNT_W'(STACK_DEPTH))
  `IEE_ASSERT_IMP(a_op_bound, 1'b1, op_cnt_q <= CNT_W'(STACK_DEPTH))
  `IEE_ASSERT_NXT(a_clear_after_out, out_load, ~|{num_cnt_q, op_cnt_q} && (err_q == iee_pkg::ST_OK))
  `IEE_ASSERT_IMP(a_err_zero_value, out_valid_o && iee_pkg::is_fatal(status_o), value_o == '0)
  `IEE_ASSERT_IMP(a_alu_in_wait, alu_busy || alu_done, state_q == S_WAIT)

endmodule
`default_nettype wire

### rtl/iee_stack_ram.sv
// Synchronous stack memory: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the evaluator top level.
`timescale 1ns / 1ps
`default_nettype none
module iee_stack_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/iee_muldiv.sv
// Multi-cycle fixed-point multiply and divide unit with saturation.
// Depends on iee_pkg; instantiated by the evaluator top level.
`timescale 1ns / 1ps
`default_nettype none
module iee_muldiv #(
  parameter int unsigned FRAC_BITS = iee_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          is_div_i,
  input  wire logic [iee_pkg::VALUE_W-1:0]   x_i,
  input  wire logic [iee_pkg::VALUE_W-1:0]   y_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [iee_pkg::VALUE_W-1:0]        result_o,
  output logic                               sat_o
);

  localparam int unsigned VW    = iee_pkg::VALUE_W;
  localparam int unsigned DIG_W = 16;
  localparam int unsigned NDIG  = VW / DIG_W;
  localparam int unsigned PPW   = VW + DIG_W;
  localparam int unsigned PW    = 2 * VW;
  localparam int unsigned DIVW  = VW + FRAC_BITS;
  localparam int unsigned CW    = $clog2(DIVW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            div_q, div_d;
  logic            neg_q, neg_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [VW-1:0]   a_q, a_d;
  logic [VW-1:0]   b_q, b_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [DIVW-1:0] dvd_q, dvd_d;
  logic [DIVW-1:0] quo_q, quo_d;
  logic [VW-1:0]   rem_q, rem_d;

  logic [VW-1:0]   mag_x, mag_y;
  logic [VW:0]     rem_sh;
  logic [PW-1:0]   mag_w, lim, mag_sat;

  assign mag_x  = x_i[VW-1] ? (~x_i + 1'b1) : x_i;
  assign mag_y  = y_i[VW-1] ? (~y_i + 1'b1) : y_i;
  assign rem_sh = {rem_q, dvd_q[DIVW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = is_div_i;
      neg_d  = x_i[VW-1] ^ y_i[VW-1];
      cnt_d  = is_div_i ? CW'(DIVW) : CW'(NDIG);
      a_d    = mag_x;
      b_d    = mag_y;
      prod_d = '0;
      dvd_d  = DIVW'(mag_x) << FRAC_BITS;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (div_q) begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, b_q}) begin
          rem_d = VW'(rem_sh - {1'b0, b_q});
          quo_d = {quo_q[DIVW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[VW-1:0];
          quo_d = {quo_q[DIVW-2:0], 1'b0};
        end
        dvd_d = dvd_q << 1;
      end else begin
        // One 16-bit digit of the multiplier per cycle, most significant first.
        prod_d = (prod_q << DIG_W) + PW'(PPW'(a_q) * PPW'(b_q[VW-1 -: DIG_W]));
        b_d    = b_q << DIG_W;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign mag_w   = div_q ? PW'(quo_q) : (prod_q >> FRAC_BITS);
  assign lim     = neg_q ? PW'(iee_pkg::VMIN_NEG) : PW'(iee_pkg::VMAX_POS);
  assign sat_o   = mag_w > lim;
  assign mag_sat = sat_o ? lim : mag_w;

  assign result_o = neg_q ? (~mag_sat[VW-1:0] + 1'b1) : mag_sat[VW-1:0];
  assign busy_o   = busy_q;
  assign done_o   = done_q;

endmodule
`default_nettype wire
